/* src/rus2x_pkg.sv */
// shared types and constants for the 2x bilinear raster upsampler
`timescale 1ns / 1ps
`default_nettype none
package rus2x_pkg;

  // sample width, signed q16.16
  localparam int SAMPLE_W = 32;

  // apb register file geometry
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // number of parity banks in the parent store
  localparam int NUM_BANKS = 4;

  // item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ODD_COL   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ODD_ROW   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_FILL = 2'd2;

  // configuration seen by the datapath
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic zero_fill;
  } cfg_t;

  // control bits that travel with an item down the pipeline
  typedef struct packed {
    logic rd;    // read item, gives a result
    logic wr;    // in-range write item
    logic zero;  // result forced to zero
    logic io;    // odd child column
    logic jo;    // odd child row
    logic cpar;  // parity of parent row c
    logic apar;  // parity of parent column a
  } ctl_t;

endpackage
`default_nettype wire

/* src/rus2x_cfg.sv */
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module rus2x_cfg import rus2x_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.odd_col   <= 1'b0;
      cfg.odd_row   <= 1'b0;
      cfg.zero_fill <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ODD_COL:   cfg.odd_col   <= pwdata[0];
        REG_ODD_ROW:   cfg.odd_row   <= pwdata[0];
        REG_ZERO_FILL: cfg.zero_fill <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ODD_COL:   prdata[0] = cfg.odd_col;
      REG_ODD_ROW:   prdata[0] = cfg.odd_row;
      REG_ZERO_FILL: prdata[0] = cfg.zero_fill;
      default:       prdata    = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/rus2x_addr.sv */
// parent coordinate and bank address stages
`timescale 1ns / 1ps
`default_nettype none
module rus2x_addr import rus2x_pkg::*; #(
  parameter int GRID_SIZE = 65,
  parameter int COORD_W   = 7,
  parameter int AW        = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          command,
  input  wire logic [COORD_W-1:0]            row,
  input  wire logic [COORD_W-1:0]            col,
  input  wire logic [SAMPLE_W-1:0]           sample_in,
  input  wire cfg_t                          cfg,
  output logic [NUM_BANKS-1:0][AW-1:0]       bank_addr,
  output logic [NUM_BANKS-1:0]               bank_we,
  output logic [SAMPLE_W-1:0]                bank_wdata,
  output ctl_t                               ctl
);

  localparam int RASTER_W = GRID_SIZE + 2;
  localparam int HALF_W   = (RASTER_W + 1) / 2;
  localparam int QUAD_OFS = (GRID_SIZE - 1) / 2;
  localparam int LAST     = GRID_SIZE + 1;
  localparam int CW1      = COORD_W + 1;

  function automatic logic [COORD_W-1:0] clamp_idx(input logic [CW1-1:0] x);
    clamp_idx = (x > CW1'(LAST)) ? COORD_W'(LAST) : x[COORD_W-1:0];
  endfunction

  // stage 1 combinational: parent coordinates
  logic               is_read;
  logic [COORD_W-1:0] row_m1, col_m1;
  logic [CW1-1:0]     pc, pa, c_raw, a_raw;
  ctl_t               ctl1_next;

  assign is_read = (command == CMD_READ);
  assign row_m1  = row - COORD_W'(1);
  assign col_m1  = col - COORD_W'(1);
  assign pc = CW1'(row_m1 >> 1) + CW1'(1) + (cfg.odd_row ? CW1'(QUAD_OFS) : '0);
  assign pa = CW1'(col_m1 >> 1) + CW1'(1) + (cfg.odd_col ? CW1'(QUAD_OFS) : '0);
  assign c_raw = is_read ? pc : CW1'(row);
  assign a_raw = is_read ? pa : CW1'(col);

  always_comb begin
    ctl1_next.rd   = start && is_read;
    ctl1_next.wr   = start && !is_read &&
                     (row <= COORD_W'(LAST)) && (col <= COORD_W'(LAST));
    ctl1_next.zero = cfg.zero_fill || (row == '0) || (col == '0) ||
                     (row > COORD_W'(GRID_SIZE)) || (col > COORD_W'(GRID_SIZE));
    ctl1_next.io   = col_m1[0];
    ctl1_next.jo   = row_m1[0];
    ctl1_next.cpar = 1'b0;
    ctl1_next.apar = 1'b0;
  end

  // stage 1 registers
  ctl_t               s1_ctl;
  logic [COORD_W-1:0] s1_c, s1_d, s1_a, s1_b;
  logic [SAMPLE_W-1:0] s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= ctl1_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_c      <= clamp_idx(c_raw);
    s1_d      <= clamp_idx(c_raw + CW1'(1));
    s1_a      <= clamp_idx(a_raw);
    s1_b      <= clamp_idx(a_raw + CW1'(1));
    s1_sample <= sample_in;
  end

  // stage 2 combinational: one parent point per parity bank
  logic [NUM_BANKS-1:0][AW-1:0] addr_next;
  logic [NUM_BANKS-1:0]         we_next;
  ctl_t                         ctl2_next;

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    localparam logic RP = 1'((k >> 1) & 1);
    localparam logic CP = 1'(k & 1);
    logic [COORD_W-1:0] rsel, csel;
    assign rsel = (s1_c[0] == RP) ? s1_c : s1_d;
    assign csel = (s1_a[0] == CP) ? s1_a : s1_b;
    assign addr_next[k] = AW'(rsel >> 1) * AW'(HALF_W) + AW'(csel >> 1);
    assign we_next[k]   = s1_ctl.wr && (s1_c[0] == RP) && (s1_a[0] == CP);
  end

  always_comb begin
    ctl2_next      = s1_ctl;
    ctl2_next.cpar = s1_c[0];
    ctl2_next.apar = s1_a[0];
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl     <= '0;
      bank_we <= '0;
    end else begin
      ctl     <= ctl2_next;
      bank_we <= we_next;
    end
  end

  always_ff @(posedge clk) begin
    bank_addr  <= addr_next;
    bank_wdata <= s1_sample;
  end

endmodule
`default_nettype wire

/* src/rus2x_bank.sv */
// one parity bank of the parent store, single port with registered read
`timescale 1ns / 1ps
`default_nettype none
module rus2x_bank import rus2x_pkg::*; #(
  parameter int DEPTH = 1156,
  parameter int AW    = 11
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       addr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // write and read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* src/rus2x_blend.sv */
// bank routing, neighbor sums and floor averaging
`timescale 1ns / 1ps
`default_nettype none
module rus2x_blend import rus2x_pkg::*; (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ctl_t                               ctl_in,
  input  wire logic [NUM_BANKS-1:0][SAMPLE_W-1:0] rdata,
  output logic                                    done,
  output logic signed [SAMPLE_W-1:0]              depth_out
);

  // align control with the registered bank data
  ctl_t c3, c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= '0;
      c4 <= '0;
    end else begin
      c3 <= ctl_in;
      c4 <= c3;
    end
  end

  // route banks to the four parent points
  logic [1:0] i_ca, i_cb, i_da, i_db;
  logic signed [SAMPLE_W:0] p_ca, p_cb, p_da, p_db;
  logic signed [SAMPLE_W:0] pair0_next, pair1_next;

  assign i_ca = {c3.cpar, c3.apar};
  assign i_cb = {c3.cpar, ~c3.apar};
  assign i_da = {~c3.cpar, c3.apar};
  assign i_db = {~c3.cpar, ~c3.apar};

  assign p_ca = (SAMPLE_W+1)'($signed(rdata[i_ca]));
  assign p_cb = (SAMPLE_W+1)'($signed(rdata[i_cb]));
  assign p_da = (SAMPLE_W+1)'($signed(rdata[i_da]));
  assign p_db = (SAMPLE_W+1)'($signed(rdata[i_db]));

  // pair sums
  assign pair0_next = p_ca + (c3.io ? p_cb : (c3.jo ? p_da : '0));
  assign pair1_next = (c3.io && c3.jo) ? (p_da + p_db) : '0;

  logic signed [SAMPLE_W:0] pair0, pair1;

  always_ff @(posedge clk) begin
    pair0 <= pair0_next;
    pair1 <= pair1_next;
  end

  // final sum and arithmetic shift
  logic signed [SAMPLE_W+1:0] total, shifted;
  logic [1:0]                 shamt;

  assign total   = (SAMPLE_W+2)'(pair0) + (SAMPLE_W+2)'(pair1);
  assign shamt   = 2'(c4.io) + 2'(c4.jo);
  assign shifted = total >>> shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c4.rd;
    end
  end

  always_ff @(posedge clk) begin
    depth_out <= c4.zero ? '0 : shifted[SAMPLE_W-1:0];
  end

endmodule
`default_nettype wire

/* src/raster_upsample_2x_bilinear.sv */
// top level of the 2x bilinear depth raster upsampler
//
// command channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so one transaction can enter every cycle.
// command 0 writes sample_in into the parent raster at (row, col), border
// included; command 1 reads the child depth at (row, col).
// each read gives one result: done is high for exactly one cycle with
// depth_out valid; it rises when the read leaves the final average stage.
// writes give no result. the receiver cannot stall, so no backpressure exists.
// throughput is one transaction per cycle: the parent raster is split into four
// banks by row and column parity, so the up to four neighbors of a child sample
// always lie in different banks, each read once per cycle on its single port.
// the pipeline is coordinate, bank address, bank read, pair sum, final average.
// a write followed by a read sees the written value, since both reach the banks
// at the same stage.
// apb port: odd_column_half at 0x0, odd_row_half at 0x4, zero_fill at 0x8.
// reset (synchronous, active high) clears the pipeline and sets the registers
// to odd halves 0, zero_fill 1. the raster itself is not cleared: an entry holds
// garbage until it is written.
`timescale 1ns / 1ps
`default_nettype none
module raster_upsample_2x_bilinear import rus2x_pkg::*; #(
  parameter  int GRID_SIZE = 65,
  localparam int COORD_W   = $clog2(GRID_SIZE + 2)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  command,
  input  wire logic [COORD_W-1:0]    row,
  input  wire logic [COORD_W-1:0]    col,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] depth_out,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int RASTER_W   = GRID_SIZE + 2;
  localparam int HALF_W     = (RASTER_W + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_W;
  localparam int AW         = $clog2(BANK_DEPTH);

  // never holds off a transaction
  assign busy = 1'b0;

  // configuration registers
  cfg_t cfg;

  rus2x_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // coordinate and bank address stages
  logic [NUM_BANKS-1:0][AW-1:0]       bank_addr;
  logic [NUM_BANKS-1:0]               bank_we;
  logic [SAMPLE_W-1:0]                bank_wdata;
  logic [NUM_BANKS-1:0][SAMPLE_W-1:0] bank_rdata;
  ctl_t                               addr_ctl;

  rus2x_addr #(
    .GRID_SIZE (GRID_SIZE),
    .COORD_W   (COORD_W),
    .AW        (AW)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .start      (start && !busy),
    .command    (command),
    .row        (row),
    .col        (col),
    .sample_in  (sample_in),
    .cfg        (cfg),
    .bank_addr  (bank_addr),
    .bank_we    (bank_we),
    .bank_wdata (bank_wdata),
    .ctl        (addr_ctl)
  );

  // parity banks of the parent raster
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    rus2x_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[k]),
      .addr  (bank_addr[k]),
      .wdata (bank_wdata),
      .rdata (bank_rdata[k])
    );
  end

  // averaging stages and result register
  rus2x_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (addr_ctl),
    .rdata     (bank_rdata),
    .done      (done),
    .depth_out (depth_out)
  );

endmodule
`default_nettype wire
